[hdl/wbps_pkg.sv]
// Shared types, constants and pattern lookup functions for the wildcard byte
// pattern scanner. Used by the cell, the output register and the top level.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int unsigned DefMaxPattern = 16;
  localparam int unsigned DefAddrBits   = 32;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned CfgW     = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CareW    = 16;
  localparam int unsigned RegLenW  = 5;
  // Wide enough for any pattern length or position up to 64.
  localparam int unsigned LenW     = 7;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow  = 2'd0,
    CfgPatternHigh = 2'd1,
    CfgCareMask    = 2'd2,
    CfgPatternLen  = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgW-1:0]  pat_lo;
    logic [CfgW-1:0]  pat_hi;
    logic [CareW-1:0] care;
  } pat_cfg_t;

  typedef struct packed {
    logic shift;  // an item is accepted this cycle
    logic flush;  // the accepted item opens a new region
  } cell_ctrl_t;

  // Pattern byte at position k; positions sixteen and above have no register bits.
  function automatic logic [ByteW-1:0] byte_at(pat_cfg_t cfg, logic [LenW-1:0] k);
    logic [CfgW-1:0] word;
    word = k[3] ? cfg.pat_hi : cfg.pat_lo;
    if (k >= LenW'(CareW)) begin
      return '0;
    end
    return word[{k[2:0], 3'b000} +: ByteW];
  endfunction

  // Care bit at position k; positions sixteen and above are wildcards.
  function automatic logic care_at(pat_cfg_t cfg, logic [LenW-1:0] k);
    if (k >= LenW'(CareW)) begin
      return 1'b0;
    end
    return cfg.care[k[3:0]];
  endfunction

endpackage

`default_nettype wire

[hdl/wildcard_byte_pattern_scanner.sv]
// Wildcard byte pattern scanner, top level. Uses wbps_pkg, wbps_cell, wbps_out_reg.
// A match address appears in the cycle after the item that completes it.
// Throughput: one item per cycle; the window cells compare in parallel and shift
// every accepted item, and only a held, stalled output register stops the input.
// Reset clears the configuration registers (length one) and all window valid flags.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner #(
  parameter int unsigned MAX_PATTERN = wbps_pkg::DefMaxPattern,
  parameter int unsigned ADDR_BITS   = wbps_pkg::DefAddrBits
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire  [wbps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire  [wbps_pkg::CfgW-1:0]    cfg_data_i,
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [wbps_pkg::ByteW-1:0]   data_byte_i,
  input  wire  [wbps_pkg::AddrW-1:0]   byte_addr_i,
  input  wire                          region_first_i,
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic [wbps_pkg::AddrW-1:0]   match_addr_o
);

  localparam int unsigned Depth = MAX_PATTERN - 1;
  localparam logic [wbps_pkg::AddrW-1:0] AddrKeep =
    (ADDR_BITS >= wbps_pkg::AddrW) ? '1 :
    ((wbps_pkg::AddrW'(1) << ADDR_BITS) - wbps_pkg::AddrW'(1));

  // Configuration registers.
  logic [wbps_pkg::CfgW-1:0]    pat_lo_q, pat_lo_d;
  logic [wbps_pkg::CfgW-1:0]    pat_hi_q, pat_hi_d;
  logic [wbps_pkg::CareW-1:0]   care_q, care_d;
  logic [wbps_pkg::RegLenW-1:0] len_q, len_d;

  always_comb begin
    pat_lo_d = pat_lo_q;
    pat_hi_d = pat_hi_q;
    care_d   = care_q;
    len_d    = len_q;
    if (cfg_we_i) begin
      case (wbps_pkg::cfg_reg_e'(cfg_idx_i))
        wbps_pkg::CfgPatternLow:  pat_lo_d = cfg_data_i;
        wbps_pkg::CfgPatternHigh: pat_hi_d = cfg_data_i;
        wbps_pkg::CfgCareMask:    care_d   = cfg_data_i[wbps_pkg::CareW-1:0];
        wbps_pkg::CfgPatternLen:  len_d    = cfg_data_i[wbps_pkg::RegLenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= wbps_pkg::RegLenW'(1);
    end else begin
      pat_lo_q <= pat_lo_d;
      pat_hi_q <= pat_hi_d;
      care_q   <= care_d;
      len_q    <= len_d;
    end
  end

  wbps_pkg::pat_cfg_t cfg;
  assign cfg.pat_lo = pat_lo_q;
  assign cfg.pat_hi = pat_hi_q;
  assign cfg.care   = care_q;

  // A length of zero acts as one, and a length past the window as the window.
  logic [wbps_pkg::LenW-1:0] len_raw, len_eff, k_head;
  assign len_raw = wbps_pkg::LenW'(len_q);
  always_comb begin
    if (len_raw == '0) begin
      len_eff = wbps_pkg::LenW'(1);
    end else if (len_raw > wbps_pkg::LenW'(MAX_PATTERN)) begin
      len_eff = wbps_pkg::LenW'(MAX_PATTERN);
    end else begin
      len_eff = len_raw;
    end
  end

  // Handshake.
  logic ready, in_acc;
  assign in_stall_o = !ready;
  assign in_acc     = in_valid_i && ready;

  wbps_pkg::cell_ctrl_t ctrl;
  assign ctrl.shift = in_acc;
  assign ctrl.flush = region_first_i;

  // The current byte always lines up with the last pattern position in use.
  assign k_head = len_eff - wbps_pkg::LenW'(1);

  logic [wbps_pkg::ByteW-1:0] byte_chain  [0:Depth];
  logic                       valid_chain [0:Depth];
  logic [Depth:0]             ok_vec;

  assign byte_chain[0]  = data_byte_i;
  assign valid_chain[0] = 1'b1;
  assign ok_vec[0] = !wbps_pkg::care_at(cfg, k_head) ||
                     (data_byte_i == wbps_pkg::byte_at(cfg, k_head));

  for (genvar b = 1; b < MAX_PATTERN; b++) begin : g_cell
    wbps_cell #(
      .POS (b)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg),
      .len_i   (len_eff),
      .byte_i  (byte_chain[b-1]),
      .valid_i (valid_chain[b-1]),
      .byte_o  (byte_chain[b]),
      .valid_o (valid_chain[b]),
      .ok_o    (ok_vec[b])
    );
  end

  logic                       hit;
  logic [wbps_pkg::AddrW-1:0] start_addr;
  assign hit        = &ok_vec;
  assign start_addr = (byte_addr_i - wbps_pkg::AddrW'(k_head)) & AddrKeep;

  wbps_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc && hit),
    .addr_i       (start_addr),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .match_addr_o (match_addr_o)
  );

`ifndef SYNTHESIS
  // A held result blocks the input so that it cannot be overwritten.
  a_stall_when_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input not stalled while a result is held");

  // Every accepted match is presented in the next cycle.
  a_hit_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && hit) |=> out_valid_o)
    else $error("accepted match not presented");

  // The first byte of a region cannot complete a pattern longer than one byte.
  a_region_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && region_first_i && (len_eff > wbps_pkg::LenW'(1))) |=> !out_valid_o)
    else $error("match reported across a region start");
`endif

endmodule

`default_nettype wire

[hdl/wbps_cell.sv]
// One window cell of the scanner: holds an earlier byte of the region and its
// valid flag, shifts them on to the next cell and checks them against the
// pattern position that lines up with it. Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell #(
  parameter int unsigned POS = 1
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wbps_pkg::cell_ctrl_t            ctrl_i,
  input  wbps_pkg::pat_cfg_t              cfg_i,
  input  wire  [wbps_pkg::LenW-1:0]       len_i,
  input  wire  [wbps_pkg::ByteW-1:0]      byte_i,
  input  wire                             valid_i,
  output logic [wbps_pkg::ByteW-1:0]      byte_o,
  output logic                            valid_o,
  output logic                            ok_o
);

  logic [wbps_pkg::ByteW-1:0] byte_q, byte_d;
  logic                       valid_q, valid_d;
  logic                       live;
  logic                       active;
  logic [wbps_pkg::LenW-1:0]  k;

  assign byte_d  = ctrl_i.shift ? byte_i : byte_q;
  assign valid_d = ctrl_i.shift ? valid_i : valid_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // A region start clears the window before the new byte is compared.
  assign live    = valid_q && !ctrl_i.flush;
  assign byte_o  = byte_q;
  assign valid_o = live;

  // The byte held here was seen POS items ago, so it lines up with
  // pattern position len - 1 - POS.
  assign active = len_i > wbps_pkg::LenW'(POS);
  assign k      = len_i - wbps_pkg::LenW'(POS) - wbps_pkg::LenW'(1);

  assign ok_o = !active ||
                (live && (!wbps_pkg::care_at(cfg_i, k) ||
                          (byte_q == wbps_pkg::byte_at(cfg_i, k))));

endmodule

`default_nettype wire

[hdl/wbps_out_reg.sv]
// Output register of the scanner: holds one match address until it is taken
// and drives the input stall from its own state and the output stall. Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_out_reg (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        load_i,
  input  wire  [wbps_pkg::AddrW-1:0] addr_i,
  output logic                       ready_o,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [wbps_pkg::AddrW-1:0] match_addr_o
);

  logic                       valid_q, valid_d;
  logic [wbps_pkg::AddrW-1:0] addr_q, addr_d;

  // The register can take a new item when empty or when its item leaves now.
  assign ready_o = !valid_q || !out_stall_i;

  assign valid_d = ready_o ? load_i : valid_q;
  assign addr_d  = (ready_o && load_i) ? addr_i : addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  assign out_valid_o  = valid_q;
  assign match_addr_o = addr_q;

endmodule

`default_nettype wire
